// File: rtl/cfp_pkg.sv
// Package for the coordinate frame parser.
// Holds the frame byte codes, the parser phase type and the result struct.
// No dependencies.
package cfp_pkg;

    // Frame byte codes
    localparam logic [7:0] HDR_X    = 8'd88;
    localparam logic [7:0] HDR_Y    = 8'd89;
    localparam logic [7:0] SIGN_POS = 8'h01;

    // Magnitude bytes folded into the value; the 32-bit word holds four at most
    localparam int VALUE_BYTES = 4;
    localparam int ACC_BYTES   = (VALUE_BYTES < 4) ? VALUE_BYTES : 4;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_SIGN = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    // One decoded goal
    typedef struct packed {
        logic               axis_is_y;
        logic signed [31:0] goal_value;
    } t_result;

endpackage

// File: rtl/cfp_parser.sv
// Frame parser state and per-byte update for the coordinate frame parser.
// Depends on cfp_pkg.
module cfp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output logic            o_done,
    output cfp_pkg::t_result o_result
);
    import cfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_axis, n_axis;
    logic        r_pos, n_pos;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_seen, n_seen;
    logic [31:0] r_acc, n_acc;

    logic [31:0] byte_shifted;
    logic [7:0]  seen_inc;

    // Place the byte at its lane of the accumulator
    assign byte_shifted = {24'd0, i_byte} << {r_seen[1:0], 3'b000};
    assign seen_inc     = r_seen + 8'd1;

    // Next state and completion
    always_comb begin
        n_phase = r_phase;
        n_axis  = r_axis;
        n_pos   = r_pos;
        n_len   = r_len;
        n_seen  = r_seen;
        n_acc   = r_acc;
        o_done  = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == HDR_X) begin
                        n_axis  = 1'b0;
                        n_phase = PH_SIGN;
                    end else if (i_byte == HDR_Y) begin
                        n_axis  = 1'b1;
                        n_phase = PH_SIGN;
                    end
                end
                PH_SIGN: begin
                    n_pos   = (i_byte == SIGN_POS);
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len  = i_byte;
                    n_seen = 8'd0;
                    n_acc  = 32'd0;
                    if (i_byte == 8'd0) begin
                        // empty payload: finish with value zero
                        o_done  = 1'b1;
                        n_len   = 8'd0;
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (r_seen < 8'(ACC_BYTES)) begin
                        n_acc = r_acc | byte_shifted;
                    end
                    n_seen = seen_inc;
                    if (seen_inc == r_len) begin
                        o_done  = 1'b1;
                        n_len   = 8'd0;
                        n_seen  = 8'd0;
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // Apply the sign to the completed magnitude
    always_comb begin
        o_result.axis_is_y  = n_axis;
        o_result.goal_value = r_pos ? $signed(n_acc) : $signed(32'd0 - n_acc);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_axis  <= 1'b0;
            r_pos   <= 1'b0;
            r_len   <= 8'd0;
            r_seen  <= 8'd0;
            r_acc   <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_axis  <= n_axis;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_acc   <= n_acc;
        end
    end

endmodule

// File: rtl/cfp_out_reg.sv
// Result register of the coordinate frame parser.
// Holds one finished goal until the downstream side takes it. Depends on cfp_pkg.
module cfp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cfp_pkg::t_result i_result,
    input  logic             i_tready,
    output logic             o_space,
    output logic             o_valid,
    output cfp_pkg::t_result o_result
);
    import cfp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held word leaves this cycle
    assign o_space  = !r_valid || i_tready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/coordinate_frame_parser.sv
// Coordinate frame parser: top level with input register, parser and result register.
// Depends on cfp_pkg, cfp_parser and cfp_out_reg.
//
// Takes one received byte per word and decodes goal frames: header (88 = X, 89 = Y,
// other bytes skipped), sign byte (0x01 positive, anything else negative), length
// byte, then that many magnitude bytes, least significant first; bytes past the
// fourth are consumed without effect. A zero length finishes at the length byte with
// value 0. Each finished frame gives one output word: tuser is the axis (1 = Y) and
// tdata the signed 32-bit goal. A byte is accepted every cycle while the output side
// keeps up; an accepted byte is held in the input register until the parser takes
// it, and its result is held in the result register. Back-pressure from the result
// register is the only thing that stalls input.
module coordinate_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] goal_value
    output logic        m_axis_tuser    // [0] axis_is_y
);
    import cfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_space;
    logic       step;
    logic       done;
    t_result    result;
    t_result    out_result;

    // Advance the held byte into the parser when the result register has room
    assign step          = r_in_valid && out_space;
    assign s_axis_tready = !r_in_valid || out_space;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    cfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_done   (done),
        .o_result (result)
    );

    cfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (done),
        .i_result (result),
        .i_tready (m_axis_tready),
        .o_space  (out_space),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = out_result.goal_value;
    assign m_axis_tuser = out_result.axis_is_y;

endmodule

// File: dv/goal_frame_checker.sv
// Goal frame checker: watches both stream channels of the coordinate frame parser,
// decodes every accepted byte on its own and compares each output word in order.
// Depends on cfp_pkg for the frame codes, the phase type and the result struct.
module goal_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_tvalid,
    input  logic        i_rx_tready,
    input  logic [7:0]  i_rx_tdata,      // [7:0] rx_byte
    input  logic        i_goal_tvalid,
    input  logic        i_goal_tready,
    input  logic [31:0] i_goal_tdata,    // [31:0] goal_value
    input  logic        i_goal_tuser,    // [0] axis_is_y
    output int          o_fail_count,
    output int          o_goals_due,
    output int          o_goals_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import cfp_pkg::*;

    // Decoder state, kept apart from the block
    t_phase      phase;
    logic        frame_is_y;
    logic        frame_positive;
    logic [7:0]  frame_length;
    logic [7:0]  payload_count;
    logic [31:0] magnitude;

    t_result goals_due[$];
    int      fails   = 0;
    int      checked = 0;

    // Advance the decoder by one byte; queue a goal when a frame completes
    task automatic parse_rx_byte(input logic [7:0] rx);
        t_result goal;
        logic    done;
        done = 1'b0;
        case (phase)
            PH_HUNT: begin
                if (rx == HDR_X) begin
                    frame_is_y = 1'b0;
                    phase      = PH_SIGN;
                end else if (rx == HDR_Y) begin
                    frame_is_y = 1'b1;
                    phase      = PH_SIGN;
                end
            end
            PH_SIGN: begin
                frame_positive = (rx == SIGN_POS);
                phase          = PH_LEN;
            end
            PH_LEN: begin
                frame_length  = rx;
                payload_count = 8'd0;
                magnitude     = 32'd0;
                if (rx == 8'd0) begin
                    done = 1'b1;
                end else begin
                    phase = PH_DATA;
                end
            end
            default: begin
                // bytes past the accumulator width are swallowed
                if (payload_count < ACC_BYTES) begin
                    magnitude = magnitude | (32'(rx) << (8 * payload_count));
                end
                payload_count = payload_count + 8'd1;
                if (payload_count == frame_length) begin
                    done = 1'b1;
                end
            end
        endcase
        if (done) begin
            goal.axis_is_y  = frame_is_y;
            goal.goal_value = frame_positive ? magnitude : (32'd0 - magnitude);
            goals_due.push_back(goal);
            phase         = PH_HUNT;
            frame_length  = 8'd0;
            payload_count = 8'd0;
        end
    endtask

    // Compare output words first, then feed the accepted byte to the decoder
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            phase          = PH_HUNT;
            frame_is_y     = 1'b0;
            frame_positive = 1'b0;
            frame_length   = 8'd0;
            payload_count  = 8'd0;
            magnitude      = 32'd0;
            goals_due.delete();
        end else begin
            if (i_goal_tvalid && i_goal_tready) begin
                if (goals_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("[%0t] unexpected goal word: axis_is_y=%0d goal_value=%0d",
                                 $realtime, i_goal_tuser, $signed(i_goal_tdata));
                    end
                end else begin
                    want = goals_due.pop_front();
                    checked++;
                    if (want.axis_is_y !== i_goal_tuser ||
                        want.goal_value !== $signed(i_goal_tdata)) begin
                        fails++;
                        if (fails <= 10) begin
                            $display(
                                "[%0t] goal mismatch: expected y=%0d val=%0d, got y=%0d val=%0d",
                                $realtime, want.axis_is_y, want.goal_value,
                                i_goal_tuser, $signed(i_goal_tdata));
                        end
                    end
                end
            end
            if (i_rx_tvalid && i_rx_tready) begin
                parse_rx_byte(i_rx_tdata);
            end
        end
        o_fail_count    <= fails;
        o_goals_due     <= goals_due.size();
        o_goals_checked <= checked;
    end

endmodule

// File: dv/testbench.sv
// Top of the coordinate frame parser testbench: clock, reset, byte stimulus with bursts
// and gaps, receiver stalls and the final verdict.
// Depends on cfp_pkg, coordinate_frame_parser and goal_frame_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cfp_pkg::*;

    localparam int LIMIT        = 200000;
    localparam int RANDOM_BYTES = 1200;

    // Directed bytes: noise while hunting, zero length, sign 0x00 with all-ones
    // magnitude, 2^31 negated, over-long payload with a magnitude above 2^31
    localparam logic [7:0] DIRECTED [27] = '{
        8'h00, 8'hFF,
        HDR_X, SIGN_POS, 8'h00,
        HDR_Y, 8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        HDR_X, 8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h80,
        HDR_Y, SIGN_POS, 8'h05, 8'h11, 8'h22, 8'h33, 8'hC4, 8'h55
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;            // [31:0] goal_value
    logic        m_axis_tuser;            // [0] axis_is_y

    int fail_count;
    int goals_due;
    int goals_checked;
    int cycles      = 0;
    int stall_tick  = 0;
    int bytes_sent  = 0;
    int noise_sent  = 0;
    int frame_bytes = 0;
    int burst_left  = 0;
    int frames      = 0;
    bit steady      = 1'b0;

    always #5 i_clk = ~i_clk;

    coordinate_frame_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    goal_frame_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_tvalid     (s_axis_tvalid),
        .i_rx_tready     (s_axis_tready),
        .i_rx_tdata      (s_axis_tdata),
        .i_goal_tvalid   (m_axis_tvalid),
        .i_goal_tready   (m_axis_tready),
        .i_goal_tdata    (m_axis_tdata),
        .i_goal_tuser    (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_goals_due     (goals_due),
        .o_goals_checked (goals_checked)
    );

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver stalls: rotate through always ready, random, periodic and long stalls
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case ((stall_tick / 256) % 4)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(3) != 0);
            2:       m_axis_tready <= ((stall_tick % 7) < 4);
            default: m_axis_tready <= ((stall_tick % 16) >= 12);
        endcase
    end

    // Present one word and hold it until accepted; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = (steady || $urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Hold off the sender until every decoded goal has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (goals_due != 0) @(negedge i_clk);
    endtask

    // One random frame: mostly well formed, some noise and some cut short
    task automatic send_random_frame();
        int         pick;
        int         len;
        int         sent_len;
        logic [7:0] sign;
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(3, 1)) begin
                send_byte(8'($urandom_range(255)));
                noise_sent++;
            end
        end else begin
            sign = ($urandom_range(1) == 1) ? SIGN_POS : 8'($urandom_range(255));
            len  = $urandom_range(99);
            if (len < 3) begin
                len = $urandom_range(255);
            end else if (len < 12) begin
                len = 0;
            end else begin
                len = $urandom_range(6, 1);
            end
            // truncated frame: the following bytes carry on where it stops
            sent_len = (pick < 16) ? $urandom_range(len) : len;
            send_byte(($urandom_range(1) == 1) ? HDR_Y : HDR_X);
            send_byte(sign);
            frame_bytes += 2;
            if (pick >= 13) begin
                send_byte(8'(len));
                frame_bytes++;
                repeat (sent_len) begin
                    send_byte(8'($urandom_range(255)));
                    frame_bytes++;
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[k]) begin
            send_byte(DIRECTED[k]);
        end
        drain();

        while (frame_bytes < RANDOM_BYTES) begin
            // run some stretches with no sender gaps
            steady = ((frames % 100) < 20);
            send_random_frame();
            frames++;
            if ($urandom_range(59) == 0) begin
                drain();
            end
        end

        drain();
        repeat (10) @(negedge i_clk);

        $display("sent %0d bytes (%0d random frames, %0d noise bytes), checked %0d goal words",
                 bytes_sent, frames, noise_sent, goals_checked);
        $display("covered zero, short, full and over-long payloads, all sign patterns,");
        $display("sender gaps and receiver stalls");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: coordinate_frame_parser.f
rtl/cfp_pkg.sv
rtl/cfp_parser.sv
rtl/cfp_out_reg.sv
rtl/coordinate_frame_parser.sv
dv/goal_frame_checker.sv
dv/testbench.sv
